FILE: rtl/mlpd_pkg.sv
`timescale 1ns / 1ps

package mlpd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned LENGTH_W  = 17;
   localparam int unsigned HDR_CNT_W = 3;

   localparam logic [WORD_W-1:0]   MAGIC_RESET      = 32'h4270_ACE1;
   localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 17'd65536;

   // header byte positions where checks happen
   localparam logic [HDR_CNT_W-1:0] HDR_MAGIC_LAST  = 3'd3;
   localparam logic [HDR_CNT_W-1:0] HDR_LENGTH_LAST = 3'd7;

   typedef enum logic [0:0] {
      CSR_MAGIC_WORD = 1'b0,
      CSR_MAX_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_BYTE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_MAGIC = 2'd2,
      ST_LONG  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_DISCARD = 3'b100
   } phase_type;

   // registered input transaction handed to the parser
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
      logic              chunk_end;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0]   magic_word;
      logic [LENGTH_W-1:0] max_payload_length;
   } cfg_type;

endpackage

FILE: rtl/mlpd_csr.sv
`timescale 1ns / 1ps

module mlpd_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [0:0]             csr_index,
   input  logic [31:0]            csr_data,
   output mlpd_pkg::cfg_type      cfg
);

   logic [mlpd_pkg::WORD_W-1:0]   magic_ff, magic_in;
   logic [mlpd_pkg::LENGTH_W-1:0] max_len_ff, max_len_in;

   assign csr_ready = 1'b1;

   always_comb begin
      magic_in   = magic_ff;
      max_len_in = max_len_ff;
      if (csr_valid) begin
         unique case (mlpd_pkg::csr_index_type'(csr_index))
            mlpd_pkg::CSR_MAGIC_WORD: magic_in   = csr_data;
            mlpd_pkg::CSR_MAX_LENGTH: max_len_in = csr_data[mlpd_pkg::LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= mlpd_pkg::MAGIC_RESET;
         max_len_ff <= mlpd_pkg::MAX_LENGTH_RESET;
      end else begin
         magic_ff   <= magic_in;
         max_len_ff <= max_len_in;
      end
   end

   assign cfg.magic_word         = magic_ff;
   assign cfg.max_payload_length = max_len_ff;

endmodule

FILE: rtl/mlpd_in_stage.sv
`timescale 1ns / 1ps

module mlpd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_chunk_end,
   input  logic                 advance,
   output mlpd_pkg::item_type   item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;

   // slot frees when the parser consumes the held transaction
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_data_byte;
         end_in   = req_chunk_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;
   assign item.chunk_end = end_ff;

endmodule

FILE: rtl/mlpd_parser.sv
`timescale 1ns / 1ps

module mlpd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  mlpd_pkg::item_type   item,
   input  mlpd_pkg::cfg_type    cfg,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_last_of_packet,
   output logic [1:0]           rsp_status
);

   mlpd_pkg::phase_type                phase_ff, phase_in;
   logic [mlpd_pkg::HDR_CNT_W-1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [mlpd_pkg::WORD_W-1:0]        shift_ff, shift_in;
   logic [mlpd_pkg::LENGTH_W-1:0]      remain_ff, remain_in;
   logic [mlpd_pkg::LENGTH_W-1:0]      remain_dec;

   logic                               out_valid_ff, out_valid_in;
   logic [7:0]                         out_byte_ff, out_byte_in;
   logic                               out_last_ff, out_last_in;
   mlpd_pkg::status_type               out_status_ff, out_status_in;

   logic                               res_valid;
   logic [7:0]                         res_byte;
   logic                               res_last;
   mlpd_pkg::status_type               res_status;

   assign advance    = item.valid && (!out_valid_ff || rsp_ready);
   assign remain_dec = remain_ff - 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      shift_in   = shift_ff;
      remain_in  = remain_ff;
      res_valid  = 1'b0;
      res_byte   = '0;
      res_last   = 1'b0;
      res_status = mlpd_pkg::ST_BYTE;

      if (advance) begin
         unique case (phase_ff)
            mlpd_pkg::PH_PAYLOAD: begin
               remain_in = remain_dec;
               res_valid = 1'b1;
               res_byte  = item.data_byte;
               if (remain_dec == '0) begin
                  phase_in = mlpd_pkg::PH_HEADER;
                  res_last = 1'b1;
               end
            end
            mlpd_pkg::PH_DISCARD: begin
               if (item.chunk_end) begin
                  phase_in = mlpd_pkg::PH_HEADER;
               end
            end
            default: begin
               phase_in = mlpd_pkg::PH_HEADER;
               shift_in = {shift_ff[mlpd_pkg::WORD_W-9:0], item.data_byte};
               if (hdr_cnt_ff == mlpd_pkg::HDR_MAGIC_LAST) begin
                  if (shift_in != cfg.magic_word) begin
                     hdr_cnt_in = '0;
                     phase_in   = item.chunk_end ? mlpd_pkg::PH_HEADER
                                                 : mlpd_pkg::PH_DISCARD;
                     res_valid  = 1'b1;
                     res_status = mlpd_pkg::ST_MAGIC;
                  end else begin
                     hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  end
               end else if (hdr_cnt_ff == mlpd_pkg::HDR_LENGTH_LAST) begin
                  hdr_cnt_in = '0;
                  if (shift_in > {{(mlpd_pkg::WORD_W-mlpd_pkg::LENGTH_W){1'b0}},
                                  cfg.max_payload_length}) begin
                     phase_in   = item.chunk_end ? mlpd_pkg::PH_HEADER
                                                 : mlpd_pkg::PH_DISCARD;
                     res_valid  = 1'b1;
                     res_status = mlpd_pkg::ST_LONG;
                  end else if (shift_in == '0) begin
                     res_valid  = 1'b1;
                     res_last   = 1'b1;
                     res_status = mlpd_pkg::ST_EMPTY;
                  end else begin
                     remain_in = shift_in[mlpd_pkg::LENGTH_W-1:0];
                     phase_in  = mlpd_pkg::PH_PAYLOAD;
                  end
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
               end
            end
         endcase
      end
   end

   // output register: loads on every consumed transaction, drains on rsp_ready
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (advance) begin
         out_valid_in  = res_valid;
         out_byte_in   = res_byte;
         out_last_in   = res_last;
         out_status_in = res_status;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mlpd_pkg::PH_HEADER;
         hdr_cnt_ff   <= '0;
         shift_ff     <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         shift_ff     <= shift_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_last_of_packet = out_last_ff;
   assign rsp_status         = out_status_ff;

endmodule

FILE: rtl/magic_length_packet_deframer.sv
`timescale 1ns / 1ps

// Packet deframer for a byte stream: 8-byte header (big-endian magic word,
// then big-endian payload length), followed by the payload bytes.
// - req_ channel: one stream byte per transaction, req_chunk_end on the last
//   byte of a received chunk. Headers may span chunks.
// - rsp_ channel: at most one transaction per input byte. Status 0 carries a
//   payload byte (last_of_packet on the final one), 1 an empty packet,
//   2 a bad magic word, 3 a length above max_payload_length. After an error
//   the rest of the chunk is dropped.
// - csr_ channel: index 0 magic word, index 1 max payload length. Always
//   ready; write only while no transaction is in flight.
// Throughput: one byte per cycle while rsp_ready does not stall. A byte
// accepted into the input register is handled by the parser, which loads
// its result into the result register that drives rsp_.
// Reset (synchronous) empties both pipeline registers, returns the parser to
// the start of a header and restores the register defaults.
// A stall on rsp_ready holds a full result register; the input register
// takes one more byte if empty, then req_ready drops until rsp_ready returns.
// While the result register is empty, bytes that cause no result move
// through without waiting on rsp_ready.

module magic_length_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_chunk_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_packet,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   mlpd_pkg::cfg_type  cfg;
   mlpd_pkg::item_type item;
   logic               advance;   // parser consumes the held input byte

   mlpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register stage
   mlpd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_chunk_end (req_chunk_end),
      .advance       (advance),
      .item          (item)
   );

   // header decode, payload count and result register
   mlpd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .item               (item),
      .cfg                (cfg),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_status         (rsp_status)
   );

endmodule

FILE: tb/tb_magic_length_packet_deframer.sv
`timescale 1ns / 1ps

module tb_magic_length_packet_deframer;

   // Run bound: about 600 bytes, each of which may wait on source gaps and
   // sink stalls; a correct run stays far below this.
   localparam int unsigned CYCLE_LIMIT   = 200_000;
   // Cycles allowed after the last result before a CSR write or the end:
   // input register plus parser stage, with margin.
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned RANDOM_BYTES  = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_chunk_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_packet;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [31:0] csr_data;

   typedef struct {
      logic [7:0]           payload_byte;
      logic                 last_of_packet;
      mlpd_pkg::status_type status;
   } deframed_rsp_type;

   // Responses still owed by the DUT, oldest first.
   deframed_rsp_type awaited_rsp[$];

   // Shadow copy of the CSRs and of the parser state.
   logic [mlpd_pkg::WORD_W-1:0]    cfg_magic;
   logic [mlpd_pkg::LENGTH_W-1:0]  cfg_max_len;
   mlpd_pkg::phase_type            parse_phase;
   logic [mlpd_pkg::HDR_CNT_W-1:0] hdr_count;
   logic [mlpd_pkg::WORD_W-1:0]    hdr_shift;
   logic [mlpd_pkg::LENGTH_W-1:0]  payload_left;

   int unsigned failures     = 0;
   int unsigned cycle_count  = 0;
   // Bytes sent outside the discard phase; bytes that are dropped don't count.
   int unsigned parsed_bytes = 0;
   bit          src_gaps     = 1'b0;
   bit          sink_stalls  = 1'b0;

   magic_length_packet_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_chunk_end      (req_chunk_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor: advances the shadow parser by one accepted byte and queues
   // the response it owes, if any.
   // -------------------------------------------------------------------------
   task automatic owe_rsp(input logic [7:0] b, input logic last,
                          input mlpd_pkg::status_type st);
      deframed_rsp_type r;
      r.payload_byte   = b;
      r.last_of_packet = last;
      r.status         = st;
      awaited_rsp.push_back(r);
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic ends);
      case (parse_phase)
         mlpd_pkg::PH_PAYLOAD: begin
            payload_left = payload_left - 1'b1;
            if (payload_left == '0) begin
               parse_phase = mlpd_pkg::PH_HEADER;
               owe_rsp(b, 1'b1, mlpd_pkg::ST_BYTE);
            end else begin
               owe_rsp(b, 1'b0, mlpd_pkg::ST_BYTE);
            end
         end
         mlpd_pkg::PH_DISCARD: begin
            // dropped up to and including the chunk end
            if (ends)
               parse_phase = mlpd_pkg::PH_HEADER;
         end
         default: begin
            parse_phase = mlpd_pkg::PH_HEADER;
            hdr_shift   = {hdr_shift[mlpd_pkg::WORD_W-9:0], b};
            if (hdr_count == mlpd_pkg::HDR_MAGIC_LAST) begin
               if (hdr_shift != cfg_magic) begin
                  hdr_count   = '0;
                  parse_phase = ends ? mlpd_pkg::PH_HEADER : mlpd_pkg::PH_DISCARD;
                  owe_rsp(8'h00, 1'b0, mlpd_pkg::ST_MAGIC);
               end else begin
                  hdr_count = mlpd_pkg::HDR_MAGIC_LAST + 1'b1;
               end
            end else if (hdr_count == mlpd_pkg::HDR_LENGTH_LAST) begin
               hdr_count = '0;
               // full 32-bit length against the 17-bit limit
               if (hdr_shift > {{(mlpd_pkg::WORD_W-mlpd_pkg::LENGTH_W){1'b0}},
                                cfg_max_len}) begin
                  parse_phase = ends ? mlpd_pkg::PH_HEADER : mlpd_pkg::PH_DISCARD;
                  owe_rsp(8'h00, 1'b0, mlpd_pkg::ST_LONG);
               end else if (hdr_shift == '0) begin
                  owe_rsp(8'h00, 1'b1, mlpd_pkg::ST_EMPTY);
               end else begin
                  payload_left = hdr_shift[mlpd_pkg::LENGTH_W-1:0];
                  parse_phase  = mlpd_pkg::PH_PAYLOAD;
               end
            end else begin
               hdr_count = hdr_count + 1'b1;
            end
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Response checker: every rsp_ transaction against the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      deframed_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected transaction: payload_byte %0h last_of_packet %0b status %0d",
                   rsp_payload_byte, rsp_last_of_packet, rsp_status);
            failures++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %0h, actual %0h",
                      want.payload_byte, rsp_payload_byte);
               failures++;
            end
            if (rsp_last_of_packet !== want.last_of_packet) begin
               $error("last_of_packet: expected %0b, actual %0b",
                      want.last_of_packet, rsp_last_of_packet);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               failures++;
            end
         end
      end
   end

   // Sink backpressure: random stall bursts on rsp_ready while enabled.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ready = 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers. All of them start and end just after a falling edge.
   // -------------------------------------------------------------------------

   // One req_ transaction; valid stays up afterwards unless a gap follows.
   task automatic send_byte(input logic [7:0] b, input logic ends);
      if (src_gaps && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      req_chunk_end = ends;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_phase != mlpd_pkg::PH_DISCARD)
         parsed_bytes++;
      deframe_byte(b, ends);
      @(negedge clock);
   endtask

   // Big-endian word; ends[3] goes with the first byte.
   task automatic send_word(input logic [31:0] w, input logic [3:0] ends);
      for (int i = 3; i >= 0; i--)
         send_byte(w[8*i +: 8], ends[i]);
   endtask

   task automatic send_payload(input int unsigned n, input int unsigned end_pct,
                               input bit end_last);
      for (int unsigned i = 0; i < n; i++)
         send_byte(8'($urandom_range(0, 255)),
                   (end_last && i == n - 1) || ($urandom_range(0, 99) < end_pct));
   endtask

   function automatic logic [3:0] chunk_marks(input int unsigned pct);
      logic [3:0] m;
      for (int i = 0; i < 4; i++)
         m[i] = ($urandom_range(0, 99) < pct);
      return m;
   endfunction

   task automatic send_packet(input logic [31:0] magic, input int unsigned len,
                              input int unsigned end_pct);
      send_word(magic, chunk_marks(end_pct));
      send_word(len, chunk_marks(end_pct));
      send_payload(len, end_pct, 1'($urandom_range(0, 1)));
   endtask

   // Filler that closes a chunk when n is nonzero, used to leave the discard phase.
   task automatic send_junk(input int unsigned n);
      send_payload(n, 0, 1'b1);
   endtask

   // Quiet the input side and wait out every owed response plus pipeline.
   task automatic settle_idle();
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input mlpd_pkg::csr_index_type idx, input logic [31:0] value);
      settle_idle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == mlpd_pkg::CSR_MAGIC_WORD)
         cfg_magic = value;
      else
         cfg_max_len = value[mlpd_pkg::LENGTH_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly well-formed packets with random content; the rest bad magic
   // words, oversize lengths and loose bytes that throw the parser off.
   task automatic run_traffic(input int unsigned n_bytes, input bit idling);
      int unsigned stop_at;
      int unsigned kind;
      int unsigned len_cap;
      logic [31:0] len_word;
      stop_at = parsed_bytes + n_bytes;
      while (parsed_bytes < stop_at) begin
         src_gaps    = idling && ($urandom_range(0, 2) != 0);
         sink_stalls = idling && ($urandom_range(0, 2) != 0);
         kind        = $urandom_range(0, 9);
         len_cap     = (cfg_max_len > 40) ? 40 : cfg_max_len;
         if (kind <= 6) begin
            send_packet(cfg_magic, $urandom_range(0, len_cap), $urandom_range(0, 20));
         end else if (kind == 7) begin
            send_word(cfg_magic ^ (32'd1 << $urandom_range(0, 31)), chunk_marks(10));
            send_junk($urandom_range(0, 5));
         end else if (kind == 8) begin
            if ($urandom_range(0, 1) == 0)
               len_word = cfg_max_len + 1 + $urandom_range(0, 300);
            else
               len_word = $urandom | 32'h0002_0000;
            send_word(cfg_magic, chunk_marks(10));
            send_word(len_word, chunk_marks(10));
            send_junk($urandom_range(0, 5));
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Default CSRs: every status, headers across chunks, chunk end on errors.
   task automatic test_reset_defaults();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      // one-byte packet, chunk end on the payload byte
      send_word(cfg_magic, 4'b0000);
      send_word(32'd1, 4'b0000);
      send_byte(8'hFF, 1'b1);
      // header over two chunks, chunk end inside the payload
      send_word(cfg_magic, 4'b0100);
      send_word(32'd3, 4'b0001);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h7F, 1'b0);
      // empty packet
      send_word(cfg_magic, 4'b0000);
      send_word(32'd0, 4'b0001);
      // bad magic mid-chunk: a good magic word in the same chunk is dropped
      send_word(cfg_magic ^ 32'd1, 4'b0000);
      send_word(cfg_magic, 4'b0000);
      send_byte(8'h55, 1'b1);
      // bad magic on a chunk end: header restarts right away
      send_word(~cfg_magic, 4'b0001);
      send_word(cfg_magic, 4'b0000);
      send_word(32'd0, 4'b0000);
      // one past the max length, then the rest of the chunk
      send_word(cfg_magic, 4'b0000);
      send_word(32'd65537, 4'b0000);
      send_junk(2);
      // all-ones length on a chunk end, then a short packet
      send_word(cfg_magic, 4'b0000);
      send_word(32'hFFFF_FFFF, 4'b0001);
      send_word(cfg_magic, 4'b0000);
      send_word(32'd2, 4'b0000);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
   endtask

   // Largest legal payload at a reduced limit, then one byte over it;
   // no idling to keep it short.
   task automatic test_max_length_packet();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, 32'd64);
      send_word(cfg_magic, 4'b0000);
      send_word(32'd64, 4'b0010);
      send_payload(64, 1, 1'b1);
      send_word(cfg_magic, 4'b0000);
      send_word(32'd65, 4'b0000);
      send_junk(1);
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, 32'(mlpd_pkg::MAX_LENGTH_RESET));
   endtask

   // Register extremes and the length limit on both sides of its edge.
   task automatic test_config_extremes();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      write_csr(mlpd_pkg::CSR_MAGIC_WORD, 32'hFFFF_FFFF);
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, 32'd0);
      send_word(32'hFFFF_FFFF, 4'b0000);
      send_word(32'd0, 4'b0000);
      send_word(32'hFFFF_FFFF, 4'b0000);
      send_word(32'd1, 4'b0001);
      write_csr(mlpd_pkg::CSR_MAGIC_WORD, 32'h0000_0000);
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, 32'd1);
      send_packet(32'h0000_0000, 1, 0);
      send_word(32'h0000_0000, 4'b0000);
      send_word(32'd2, 4'b0000);
      send_junk(1);
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, 32'd5);
      send_packet(32'h0000_0000, 5, 0);
      send_word(32'h0000_0000, 4'b0000);
      send_word(32'd6, 4'b0000);
      send_junk(1);
      write_csr(mlpd_pkg::CSR_MAGIC_WORD, mlpd_pkg::MAGIC_RESET);
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, 32'(mlpd_pkg::MAX_LENGTH_RESET));
   endtask

   // Several CSR settings, each with a stretch of mixed traffic.
   task automatic test_random_traffic();
      logic [31:0] magic;
      logic [31:0] max_len;
      for (int p = 0; p < 6; p++) begin
         case ($urandom_range(0, 3))
            0:       magic = 32'h0000_0000;
            1:       magic = 32'hFFFF_FFFF;
            default: magic = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       max_len = $urandom_range(0, 3);
            1:       max_len = 32'd65536;
            default: max_len = $urandom_range(4, 65536);
         endcase
         write_csr(mlpd_pkg::CSR_MAGIC_WORD, magic);
         write_csr(mlpd_pkg::CSR_MAX_LENGTH, max_len);
         run_traffic(RANDOM_BYTES / 6, 1'b1);
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_no_idle();
      write_csr(mlpd_pkg::CSR_MAGIC_WORD, $urandom);
      write_csr(mlpd_pkg::CSR_MAX_LENGTH, $urandom_range(8, 64));
      run_traffic(100, 1'b0);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_chunk_end = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = mlpd_pkg::CSR_MAGIC_WORD;
      csr_data      = '0;
      cfg_magic     = mlpd_pkg::MAGIC_RESET;
      cfg_max_len   = mlpd_pkg::MAX_LENGTH_RESET;
      parse_phase   = mlpd_pkg::PH_HEADER;
      hdr_count     = '0;
      hdr_shift     = '0;
      payload_left  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_max_length_packet();
      test_config_extremes();
      test_random_traffic();
      test_no_idle();

      settle_idle();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
